>>> hw/rtl/tvdc_pkg.sv
// Shared types and constants for the triangle vertex decode and cull block.
package tvdc_pkg;

    localparam int NUM_VERT   = 3;
    localparam int NUM_AXIS   = 3;
    localparam int BYTE_W     = 8;
    localparam int SCALE_W    = 24;
    localparam int ORIGIN_W   = 32;
    localparam int PROD_W     = BYTE_W + SCALE_W;
    localparam int COORD_W    = 34;
    localparam int DIFF_W     = BYTE_W + 1;
    localparam int XPROD_W    = 2 * DIFF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = NUM_VERT * NUM_AXIS * BYTE_W;
    localparam int OUT_DATA_W = ((NUM_VERT * NUM_AXIS * COORD_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X  = 3'd0,
        CFG_SCALE_Y  = 3'd1,
        CFG_SCALE_Z  = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5
    } t_cfg_idx;

    // load enables of the product and coordinate stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

>>> hw/rtl/triangle_vertex_decode_cull.sv
// Top level: triangle vertex decode and degenerate-triangle cull pipeline.
//
// Channel  Dir  Word / fields (low bit first)
// s        in   tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z; tlast: end_of_model
// m        out  tdata: pa_x pa_y pa_z pb_x pb_y pb_z pc_x pc_y pc_z, pad; tuser: keep;
//               tlast: last_out
// cfg      in   index: register 0..5; data: scale (bits 23:0) or origin (31:0)
//
// Three register stages: byte swap and differences, products, sums and cull flag.
// One word per cycle unless output stalls; words pass the stage 1, 2 and 3 registers.
// A stage loads when it is empty or the stage after it moves; a stall holds every word.
// Reset clears valid bits and loads default scales (1.0) and origins (0).
// Config writes are always ready; scales are read in stages 2 and 3, origins in stage 3,
// so write registers only while the pipeline is empty; the block does not enforce it.
module triangle_vertex_decode_cull (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [tvdc_pkg::IN_DATA_W-1:0]        i_s_tdata,   // a_x a_y a_z b_x .. c_z
    input  logic                                  i_s_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [tvdc_pkg::OUT_DATA_W-1:0]       o_m_tdata,   // pa_x pa_y pa_z pb_x .. pc_z
    output logic                                  o_m_tuser,   // keep
    output logic                                  o_m_tlast,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tvdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tvdc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int NV = tvdc_pkg::NUM_VERT;
    localparam int NA = tvdc_pkg::NUM_AXIS;
    localparam int BW = tvdc_pkg::BYTE_W;
    localparam int DW = tvdc_pkg::DIFF_W;
    localparam int XW = tvdc_pkg::XPROD_W;
    localparam int CW = tvdc_pkg::COORD_W;

    logic [tvdc_pkg::SCALE_W-1:0]  r_scale_x, r_scale_y, r_scale_z;
    logic [tvdc_pkg::ORIGIN_W-1:0] r_origin_x, r_origin_y, r_origin_z;

    logic r_v1, r_v2, r_v3;
    logic r_last1, r_last2, r_last3;
    logic r_keep3;
    logic load_s1, load_s2, load_s3;
    tvdc_pkg::t_stage_en stage_en;

    // stage 1: bytes in output axis order, and vertex differences
    logic [BW-1:0]        r_vb [NV][NA];
    logic signed [DW-1:0] r_u1 [NA];
    logic signed [DW-1:0] r_u2 [NA];
    logic [BW-1:0]        in_b [NV][NA];

    // stage 2: cross-product partial products
    logic signed [XW-1:0] r_xp [6];

    logic [tvdc_pkg::SCALE_W-1:0]  axis_scale  [NA];
    logic [tvdc_pkg::ORIGIN_W-1:0] axis_origin [NA];
    logic [CW-1:0]                 coord [NV][NA];

    logic sx_nz, sy_nz, sz_nz;
    logic n_keep;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= tvdc_pkg::SCALE_W'(65536);
            r_scale_y  <= tvdc_pkg::SCALE_W'(65536);
            r_scale_z  <= tvdc_pkg::SCALE_W'(65536);
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
        end else if (i_cfg_valid) begin
            case (tvdc_pkg::t_cfg_idx'(i_cfg_index))
                tvdc_pkg::CFG_SCALE_X:  r_scale_x  <= i_cfg_data[tvdc_pkg::SCALE_W-1:0];
                tvdc_pkg::CFG_SCALE_Y:  r_scale_y  <= i_cfg_data[tvdc_pkg::SCALE_W-1:0];
                tvdc_pkg::CFG_SCALE_Z:  r_scale_z  <= i_cfg_data[tvdc_pkg::SCALE_W-1:0];
                tvdc_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                tvdc_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                tvdc_pkg::CFG_ORIGIN_Z: r_origin_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // flow control
    assign load_s3     = !r_v3 || i_m_tready;
    assign load_s2     = !r_v2 || load_s3;
    assign load_s1     = !r_v1 || load_s2;
    assign o_s_tready  = load_s1;
    assign stage_en.s2 = load_s2;
    assign stage_en.s3 = load_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load_s1) r_v1 <= i_s_tvalid;
            if (load_s2) r_v2 <= r_v1;
            if (load_s3) r_v3 <= r_v2;
        end
    end

    // swap: out x <- model x, out y <- model z, out z <- model y
    always_comb begin
        for (int k = 0; k < NV; k++) begin
            in_b[k][0] = i_s_tdata[(k*NA + 0)*BW +: BW];
            in_b[k][1] = i_s_tdata[(k*NA + 2)*BW +: BW];
            in_b[k][2] = i_s_tdata[(k*NA + 1)*BW +: BW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_last1 <= i_s_tlast;
            for (int k = 0; k < NV; k++) begin
                for (int j = 0; j < NA; j++) begin
                    r_vb[k][j] <= in_b[k][j];
                end
            end
            for (int j = 0; j < NA; j++) begin
                r_u1[j] <= $signed({1'b0, in_b[1][j]}) - $signed({1'b0, in_b[0][j]});
                r_u2[j] <= $signed({1'b0, in_b[2][j]}) - $signed({1'b0, in_b[0][j]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s2) begin
            r_last2 <= r_last1;
            r_xp[0] <= r_u1[1] * r_u2[2];
            r_xp[1] <= r_u1[2] * r_u2[1];
            r_xp[2] <= r_u1[2] * r_u2[0];
            r_xp[3] <= r_u1[0] * r_u2[2];
            r_xp[4] <= r_u1[0] * r_u2[1];
            r_xp[5] <= r_u1[1] * r_u2[0];
        end
    end

    assign sx_nz = (r_scale_x != '0);
    assign sy_nz = (r_scale_y != '0);
    assign sz_nz = (r_scale_z != '0);

    // a cross component is zero iff its byte cross term or one of its scales is zero
    assign n_keep = ((r_xp[0] != r_xp[1]) && sz_nz && sy_nz)
                 || ((r_xp[2] != r_xp[3]) && sy_nz && sx_nz)
                 || ((r_xp[4] != r_xp[5]) && sx_nz && sz_nz);

    always_ff @(posedge i_clk) begin
        if (load_s3) begin
            r_last3 <= r_last2;
            r_keep3 <= n_keep;
        end
    end

    assign axis_scale[0]  = r_scale_x;
    assign axis_scale[1]  = r_scale_z;
    assign axis_scale[2]  = r_scale_y;
    assign axis_origin[0] = r_origin_x;
    assign axis_origin[1] = r_origin_y;
    assign axis_origin[2] = r_origin_z;

    for (genvar gk = 0; gk < NV; gk++) begin : g_vert
        for (genvar gj = 0; gj < NA; gj++) begin : g_axis
            tvdc_axis u_axis (
                .i_clk    (i_clk),
                .i_en     (stage_en),
                .i_byte   (r_vb[gk][gj]),
                .i_scale  (axis_scale[gj]),
                .i_origin (axis_origin[gj]),
                .o_coord  (coord[gk][gj])
            );
            assign o_m_tdata[(gk*NA + gj)*CW +: CW] = coord[gk][gj];
        end
    end

    assign o_m_tdata[tvdc_pkg::OUT_DATA_W-1:NV*NA*CW] = '0;
    assign o_m_tvalid = r_v3;
    assign o_m_tuser  = r_keep3;
    assign o_m_tlast  = r_last3;

    // input backs up only when every stage holds a word
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free pipeline stage");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_s_tvalid && o_s_tready) |=> r_v1)
        else $error("accepted word lost at stage 1");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_v2 && r_v3 && !i_m_tready) |=> (r_v2 && r_v3))
        else $error("stalled word dropped from stage 2 or 3");

endmodule

>>> hw/rtl/tvdc_axis.sv
// One coordinate lane: byte times scale, then plus sign-extended origin.
module tvdc_axis (
    input  logic                                 i_clk,
    input  tvdc_pkg::t_stage_en                  i_en,
    input  logic [tvdc_pkg::BYTE_W-1:0]          i_byte,
    input  logic [tvdc_pkg::SCALE_W-1:0]         i_scale,
    input  logic [tvdc_pkg::ORIGIN_W-1:0]        i_origin,
    output logic [tvdc_pkg::COORD_W-1:0]         o_coord
);

    logic [tvdc_pkg::PROD_W-1:0]  r_prod;
    logic [tvdc_pkg::COORD_W-1:0] r_coord;
    logic [tvdc_pkg::COORD_W-1:0] n_coord;

    always_comb begin
        n_coord = {{(tvdc_pkg::COORD_W - tvdc_pkg::PROD_W){1'b0}}, r_prod}
                + {{(tvdc_pkg::COORD_W - tvdc_pkg::ORIGIN_W){i_origin[tvdc_pkg::ORIGIN_W-1]}},
                   i_origin};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod <= {{tvdc_pkg::SCALE_W{1'b0}}, i_byte} * {{tvdc_pkg::BYTE_W{1'b0}}, i_scale};
        end
        if (i_en.s3) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for triangle_vertex_decode_cull: directed table, then random bursts.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_ITEMS  = 1250;
    localparam int DRAIN_WAIT  = 4;
    // output axis j takes model axis OUT_SRC[j]: x <- x, y <- z, z <- y
    localparam int OUT_SRC [3] = '{0, 2, 1};

    typedef struct packed {
        logic                                 eom;
        logic [8:0][tvdc_pkg::BYTE_W-1:0]     byt;    // a_x a_y a_z b_x .. c_z, low index first
    } t_tri_in;

    typedef struct packed {
        logic                                 last;
        logic                                 keep;
        logic [8:0][tvdc_pkg::COORD_W-1:0]    crd;    // pa_x pa_y pa_z pb_x .. pc_z
    } t_tri_out;

    typedef enum logic [1:0] {
        ROW_TRI,
        ROW_KNOWN,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic                             keep;
        tvdc_pkg::t_cfg_idx               idx;
        logic [tvdc_pkg::CFG_DATA_W-1:0]  data;
        t_tri_in                          verts;
    } t_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [tvdc_pkg::IN_DATA_W-1:0]   i_s_tdata = '0;
    logic                             i_s_tlast = 1'b0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [tvdc_pkg::OUT_DATA_W-1:0]  o_m_tdata;
    logic                             o_m_tuser;
    logic                             o_m_tlast;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tvdc_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [tvdc_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic [tvdc_pkg::SCALE_W-1:0]         scale_reg [3];   // by model axis
    logic signed [tvdc_pkg::ORIGIN_W-1:0] origin_reg [3];  // by output axis
    t_tri_out                             decoded_q [$];
    t_row                                 dir_tab [$];
    int                                   n_mismatch = 0;
    int                                   n_cycles = 0;
    int                                   burst_left = 0;

    triangle_vertex_decode_cull u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_tri_out decode_triangle(t_tri_in t);
        int       v [3][3];
        int       u1 [3];
        int       u2 [3];
        int       cr [3];
        logic     sc_nz [3];
        longint   sum;
        t_tri_out r;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                v[k][j] = int'(t.byt[3 * k + OUT_SRC[j]]);
                sum = longint'(v[k][j]) * longint'(scale_reg[OUT_SRC[j]])
                      + longint'(origin_reg[j]);
                r.crd[3 * k + j] = sum[tvdc_pkg::COORD_W-1:0];
            end
        end
        for (int j = 0; j < 3; j++) begin
            u1[j] = v[1][j] - v[0][j];
            u2[j] = v[2][j] - v[0][j];
            sc_nz[j] = (scale_reg[OUT_SRC[j]] != 0);
        end
        cr[0] = u1[1] * u2[2] - u1[2] * u2[1];
        cr[1] = u1[2] * u2[0] - u1[0] * u2[2];
        cr[2] = u1[0] * u2[1] - u1[1] * u2[0];
        r.keep = (cr[0] != 0 && sc_nz[1] && sc_nz[2])
              || (cr[1] != 0 && sc_nz[2] && sc_nz[0])
              || (cr[2] != 0 && sc_nz[0] && sc_nz[1]);
        r.last = t.eom;
        return r;
    endfunction

    function automatic t_row mk_tri(t_row_kind kind, logic keep, logic eom,
                                    logic [7:0] ax, logic [7:0] ay, logic [7:0] az,
                                    logic [7:0] bx, logic [7:0] by, logic [7:0] bz,
                                    logic [7:0] cx, logic [7:0] cy, logic [7:0] cz);
        t_row r;
        r = '0;
        r.kind = kind;
        r.keep = keep;
        r.verts.eom = eom;
        r.verts.byt = {cz, cy, cx, bz, by, bx, az, ay, ax};
        return r;
    endfunction

    function automatic t_row mk_reg(tvdc_pkg::t_cfg_idx idx,
                                    logic [tvdc_pkg::CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        dir_tab.insert(dir_tab.size(), r);
    endfunction

    task automatic send_tri(input t_tri_in t, input t_tri_out want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= t.byt;
        i_s_tlast <= t.eom;
        do @(posedge i_clk); while (!o_s_tready);
        decoded_q.insert(decoded_q.size(), want);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input tvdc_pkg::t_cfg_idx idx,
                             input logic [tvdc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tvdc_pkg::CFG_SCALE_X:  scale_reg[0] = data[tvdc_pkg::SCALE_W-1:0];
            tvdc_pkg::CFG_SCALE_Y:  scale_reg[1] = data[tvdc_pkg::SCALE_W-1:0];
            tvdc_pkg::CFG_SCALE_Z:  scale_reg[2] = data[tvdc_pkg::SCALE_W-1:0];
            tvdc_pkg::CFG_ORIGIN_X: origin_reg[0] = data;
            tvdc_pkg::CFG_ORIGIN_Y: origin_reg[1] = data;
            tvdc_pkg::CFG_ORIGIN_Z: origin_reg[2] = data;
            default: ;
        endcase
    endtask

    // receiver stalls
    logic [15:0] stall_pat = '1;
    int          stall_mode = 0;
    int          stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(16, 96);
            stall_mode = $urandom_range(0, 3);
            stall_pat = 16'($urandom);
        end
        stall_left--;
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= stall_pat[0];
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= stall_pat[0] | stall_pat[3];
        endcase
    end

    always @(posedge i_clk) begin
        t_tri_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                n_mismatch++;
                $display("%0t: word with nothing expected, expected none got %h",
                         $time, o_m_tdata);
            end else begin
                want = decoded_q.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (o_m_tdata[k * tvdc_pkg::COORD_W +: tvdc_pkg::COORD_W]
                        !== want.crd[k]) begin
                        n_mismatch++;
                        $display("%0t: coord %0d expected %0d got %0d", $time, k,
                                 $signed(want.crd[k]),
                                 $signed(o_m_tdata[k * tvdc_pkg::COORD_W +:
                                                   tvdc_pkg::COORD_W]));
                    end
                end
                if (o_m_tuser !== want.keep) begin
                    n_mismatch++;
                    $display("%0t: keep expected %b got %b", $time, want.keep, o_m_tuser);
                end
                if (o_m_tlast !== want.last) begin
                    n_mismatch++;
                    $display("%0t: last expected %b got %b", $time, want.last, o_m_tlast);
                end
            end
        end
    end

    initial begin
        t_tri_out want;
        t_tri_in  tv;
        tvdc_pkg::t_cfg_idx ri;
        logic [tvdc_pkg::CFG_DATA_W-1:0] val;
        int       n_sent;
        int       pick;
        int       phase_len;
        int       shape;
        logic [7:0] base;
        logic [7:0] step;

        scale_reg = '{24'h010000, 24'h010000, 24'h010000};
        origin_reg = '{32'sd0, 32'sd0, 32'sd0};
        n_sent = 0;

        // reset defaults: scale 1.0, origin 0
        add_row(mk_tri(ROW_KNOWN, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_tri(ROW_KNOWN, 1'b0, 1'b1,
                       255, 255, 255, 255, 255, 255, 255, 255, 255));
        add_row(mk_tri(ROW_KNOWN, 1'b1, 1'b0, 0, 0, 0, 255, 0, 0, 0, 255, 0));
        add_row(mk_tri(ROW_KNOWN, 1'b1, 1'b0, 0, 0, 0, 255, 0, 0, 0, 0, 255));
        // collinear and repeated vertex
        add_row(mk_tri(ROW_KNOWN, 1'b0, 1'b0, 0, 0, 0, 1, 1, 1, 2, 2, 2));
        add_row(mk_tri(ROW_KNOWN, 1'b0, 1'b1, 10, 20, 30, 10, 20, 30, 40, 5, 200));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0,
                       8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h01, 8'h80, 8'h7E));
        // largest coordinates
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_X, 32'h00FF_FFFF));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_Y, 32'h00FF_FFFF));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_Z, 32'h00FF_FFFF));
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_X, 32'h7FFF_FFFF));
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF));
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_Z, 32'h7FFF_FFFF));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b1,
                       255, 255, 255, 255, 255, 255, 255, 255, 255));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0, 0, 0, 0, 255, 0, 0, 0, 255, 255));
        // most negative coordinates
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_X, 32'h8000_0000));
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_Y, 32'h8000_0000));
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_Z, 32'h8000_0000));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b1, 0, 255, 7, 200, 3, 90, 17, 128, 255));
        // zero scale kills the components that use it
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_X, 32'h0));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0, 0, 0, 0, 255, 0, 0, 0, 255, 0));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0, 0, 0, 0, 0, 255, 0, 0, 0, 255));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_X, 32'h0001_0000));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_Y, 32'h0));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0, 0, 0, 0, 255, 0, 0, 0, 255, 0));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_Y, 32'h0001_0000));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_Z, 32'h0));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b0, 0, 0, 0, 255, 0, 0, 0, 0, 255));
        add_row(mk_reg(tvdc_pkg::CFG_SCALE_Z, 32'h0012_3456));
        add_row(mk_reg(tvdc_pkg::CFG_ORIGIN_Y, 32'hFFFF_8000));
        add_row(mk_tri(ROW_TRI, 1'b0, 1'b1, 3, 250, 9, 77, 1, 180, 255, 66, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < dir_tab.size(); r++) begin
            if (dir_tab[r].kind == ROW_REG) begin
                if (r == 0 || dir_tab[r - 1].kind != ROW_REG) drain();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
                if (r + 1 == dir_tab.size() || dir_tab[r + 1].kind != ROW_REG)
                    i_cfg_valid <= 1'b0;
            end else begin
                want = decode_triangle(dir_tab[r].verts);
                if (dir_tab[r].kind == ROW_KNOWN) begin
                    for (int k = 0; k < 3; k++)
                        for (int j = 0; j < 3; j++)
                            want.crd[3 * k + j] =
                                tvdc_pkg::COORD_W'(dir_tab[r].verts.byt[3 * k + OUT_SRC[j]])
                                << 16;
                    want.keep = dir_tab[r].keep;
                    want.last = dir_tab[r].verts.eom;
                end
                send_tri(dir_tab[r].verts, want);
            end
        end

        while (n_sent < RAND_ITEMS) begin
            drain();
            ri = ri.first();
            do begin
                pick = $urandom_range(0, 7);
                if (ri inside {tvdc_pkg::CFG_SCALE_X, tvdc_pkg::CFG_SCALE_Y,
                               tvdc_pkg::CFG_SCALE_Z}) begin
                    case (pick)
                        0: val = 32'h0;
                        1: val = 32'h00FF_FFFF;
                        2, 3: val = 32'h0001_0000;
                        default: val = $urandom & 32'h00FF_FFFF;
                    endcase
                end else begin
                    case (pick)
                        0: val = 32'h8000_0000;
                        1: val = 32'h7FFF_FFFF;
                        2, 3: val = 32'h0;
                        default: val = $urandom;
                    endcase
                end
                write_reg(ri, val);
                ri = ri.next();
            end while (ri != ri.first());
            i_cfg_valid <= 1'b0;

            phase_len = $urandom_range(40, 200);
            if (phase_len > RAND_ITEMS - n_sent) phase_len = RAND_ITEMS - n_sent;
            repeat (phase_len) begin
                shape = $urandom_range(0, 99);
                for (int k = 0; k < 9; k++) tv.byt[k] = 8'($urandom);
                if (shape < 60) begin
                    // random content
                end else if (shape < 70) begin
                    // repeated vertex
                    for (int j = 0; j < 3; j++)
                        if (shape < 65) tv.byt[3 + j] = tv.byt[j];
                        else tv.byt[6 + j] = tv.byt[3 + j];
                end else if (shape < 80) begin
                    // collinear
                    for (int j = 0; j < 3; j++) begin
                        base = 8'($urandom_range(0, 127));
                        step = 8'($urandom_range(0, 63));
                        tv.byt[j] = base;
                        tv.byt[3 + j] = base + step;
                        tv.byt[6 + j] = base + 2 * step;
                    end
                end else if (shape < 90) begin
                    for (int k = 0; k < 9; k++) tv.byt[k] = 8'($urandom_range(0, 1));
                end else begin
                    for (int k = 0; k < 9; k++)
                        tv.byt[k] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                end
                tv.eom = ($urandom_range(0, 7) == 0);
                send_tri(tv, decode_triangle(tv));
                n_sent++;
            end
        end

        drain();
        if (n_mismatch == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
